FILE: rtl/bgim_pkg.sv
package bgim_pkg;

    // Grid limits and derived storage sizes
    localparam int MAX_X      = 16;
    localparam int MAX_Y      = 16;
    localparam int MAX_Z      = 16;
    localparam int CELL_COUNT = MAX_X * MAX_Y * MAX_Z;
    localparam int ADDR_W     = (CELL_COUNT > 1) ? $clog2(CELL_COUNT) : 1;
    localparam int YZ_W       = (MAX_Y * MAX_Z > 1) ? $clog2(MAX_Y * MAX_Z) : 1;

    // Field widths
    localparam int SIZE_W     = 5;
    localparam int COORD_W    = 5;
    localparam int START_W    = 4;
    localparam int NUM_W      = 16;
    localparam int CELL_W     = NUM_W + 1;
    localparam int SLOT_W     = 5;
    localparam int NEIGHBOURS = 26;

    localparam logic [NUM_W-1:0]  ALL_ONES   = '1;
    localparam logic [SIZE_W-1:0] SIZE_RESET = SIZE_W'(16);

    // Configuration port
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 5;
    localparam logic [CFG_IDX_W-1:0] CFG_SIZE_X = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SIZE_Y = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SIZE_Z = 2'd2;

    // Neighbour offset codes (offset plus one)
    localparam logic [1:0] D_MINUS = 2'd0;
    localparam logic [1:0] D_ZERO  = 2'd1;
    localparam logic [1:0] D_PLUS  = 2'd2;

    typedef enum logic [1:0] {
        REQ_ALLOC  = 2'd0,
        REQ_ASSIGN = 2'd1,
        REQ_LOOKUP = 2'd2,
        REQ_NEIGH  = 2'd3
    } req_t;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_MOD,
        ST_YZ,
        ST_BOX,
        ST_RESULT,
        ST_RD,
        ST_WAIT,
        ST_NB_PREP
    } seq_state_t;

    typedef struct packed {
        req_t                req_type;
        logic [START_W-1:0]  start_x;
        logic [START_W-1:0]  start_y;
        logic [START_W-1:0]  start_z;
        logic [COORD_W-1:0]  end_x;
        logic [COORD_W-1:0]  end_y;
        logic [COORD_W-1:0]  end_z;
        logic                keep_counting;
        logic [NUM_W-1:0]    given_number;
    } in_item_t;

    typedef struct packed {
        logic [NUM_W-1:0]    brick_number;
        logic [NUM_W-1:0]    owner_number;
        logic [SLOT_W-1:0]   slot;
        logic [NUM_W-1:0]    counter_value;
        logic                unassigned;
        logic                overflow;
        logic                last;
    } out_item_t;

    typedef struct packed {
        logic [SIZE_W-1:0] sx;
        logic [SIZE_W-1:0] sy;
        logic [SIZE_W-1:0] sz;
    } grid_size_t;

    typedef struct packed {
        logic              we;
        logic [ADDR_W-1:0] waddr;
        logic [CELL_W-1:0] wdata;
        logic              re;
        logic [ADDR_W-1:0] raddr;
    } ram_cmd_t;

    // Zero reads as one, values above the limit saturate
    function automatic logic [SIZE_W-1:0] eff_size(input logic [SIZE_W-1:0] raw,
                                                   input int limit);
        logic [SIZE_W-1:0] result;
        if (raw == '0)
            result = SIZE_W'(1);
        else if (int'(raw) > limit)
            result = SIZE_W'(limit);
        else
            result = raw;
        return result;
    endfunction

    // Clip a box end to the grid extent
    function automatic logic [COORD_W-1:0] clip_end(input logic [COORD_W-1:0] e,
                                                    input logic [SIZE_W-1:0] s);
        logic [COORD_W-1:0] result;
        if (e > COORD_W'(s))
            result = COORD_W'(s);
        else
            result = e;
        return result;
    endfunction

    // Periodic neighbour coordinate, c is below s
    function automatic logic [COORD_W-1:0] wrap_coord(input logic [COORD_W-1:0] c,
                                                      input logic [1:0] d,
                                                      input logic [SIZE_W-1:0] s);
        logic [COORD_W-1:0] result;
        if (d == D_MINUS)
            result = (c == '0) ? COORD_W'(s - 1'b1) : c - 1'b1;
        else if (d == D_PLUS)
            result = (c + 1'b1 == COORD_W'(s)) ? '0 : c + 1'b1;
        else
            result = c;
        return result;
    endfunction

endpackage

FILE: rtl/bgim_ram.sv
module bgim_ram #(
    parameter int WIDTH = 17,
    parameter int DEPTH = 4096
) (
    input  logic                       clk,
    input  logic                       we,
    input  logic [$clog2(DEPTH)-1:0]   waddr,
    input  logic [WIDTH-1:0]           wdata,
    input  logic                       re,
    input  logic [$clog2(DEPTH)-1:0]   raddr,
    output logic [WIDTH-1:0]           rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
    end

    // Registered read, hold data while idle
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

FILE: rtl/bgim_seq.sv
module bgim_seq (
    input  logic                          clk,
    input  logic                          rst_n,
    input  bgim_pkg::grid_size_t          grid,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  bgim_pkg::in_item_t            in_data,
    output logic                          res_valid,
    input  logic                          res_ready,
    output bgim_pkg::out_item_t           res_data,
    output bgim_pkg::ram_cmd_t            ram_cmd,
    input  logic [bgim_pkg::CELL_W-1:0]   ram_rdata
);

    localparam int CW    = bgim_pkg::COORD_W;
    localparam int AW    = bgim_pkg::ADDR_W;
    localparam int NW    = bgim_pkg::NUM_W;
    localparam int YW    = bgim_pkg::YZ_W;
    localparam int ZP_W  = 2 * CW;
    localparam int RP_W  = YW + bgim_pkg::SIZE_W;
    localparam logic [AW-1:0] LAST_ADDR = AW'(bgim_pkg::CELL_COUNT - 1);
    localparam logic [bgim_pkg::SLOT_W-1:0] LAST_SLOT =
        bgim_pkg::SLOT_W'(bgim_pkg::NEIGHBOURS - 1);

    bgim_pkg::seq_state_t state_reg, state_next;
    bgim_pkg::req_t       req_reg, req_next;

    logic                 keep_reg, keep_next;
    logic [NW-1:0]        given_reg, given_next;
    logic [CW-1:0]        x0_reg, x0_next, y0_reg, y0_next;
    logic [CW-1:0]        x1_reg, x1_next, y1_reg, y1_next, z1_reg, z1_next;
    logic [CW-1:0]        x_reg, x_next, y_reg, y_next, z_reg, z_next;
    logic [CW-1:0]        cx_reg, cx_next, cy_reg, cy_next, cz_reg, cz_next;
    logic [YW-1:0]        yz_reg, yz_next;
    logic [1:0]           dx_reg, dx_next, dy_reg, dy_next, dz_reg, dz_next;
    logic [bgim_pkg::SLOT_W-1:0] slot_reg, slot_next;
    logic                 nb_phase_reg, nb_phase_next;
    logic                 cset_reg, cset_next;
    logic [NW-1:0]        cnum_reg, cnum_next;
    logic [NW-1:0]        next_num_reg, next_num_next;
    logic                 ovf_reg, ovf_next;
    logic                 pend_reg, pend_next;
    logic [AW-1:0]        pend_addr_reg, pend_addr_next;
    logic [AW-1:0]        clr_addr_reg, clr_addr_next;

    logic                 accept;
    logic [ZP_W-1:0]      zprod;
    logic [YW-1:0]        yz_calc;
    logic [RP_W-1:0]      row_prod;
    logic [AW-1:0]        rd_addr;
    logic                 cell_set;
    logic [NW-1:0]        cell_num;
    logic [NW-1:0]        cell_val;
    logic                 upd_write;
    logic                 upd_adv;
    logic [CW-1:0]        ax1, ay1, az1;
    logic                 box_empty;
    logic [1:0]           dx_adv, dy_adv, dz_adv;

    assign accept = in_valid && in_ready;

    // Plane row index and cell address of the current coordinates
    assign zprod    = ZP_W'(z_reg) * ZP_W'(grid.sy);
    assign yz_calc  = YW'(ZP_W'(y_reg) + zprod);
    assign row_prod = RP_W'(yz_reg) * RP_W'(grid.sx);
    assign rd_addr  = AW'(x_reg) + AW'(row_prod);

    // Cell returned by the memory
    assign cell_set = ram_rdata[bgim_pkg::CELL_W-1];
    assign cell_num = ram_rdata[NW-1:0];
    assign cell_val = cell_set ? cell_num : bgim_pkg::ALL_ONES;

    // Box walk update of the cell read last cycle
    assign upd_write = pend_reg && !cell_set;
    assign upd_adv   = pend_reg && (req_reg == bgim_pkg::REQ_ALLOC) &&
                       (!cell_set || keep_reg);

    // Clipped box of the incoming transaction
    assign ax1 = bgim_pkg::clip_end(in_data.end_x, grid.sx);
    assign ay1 = bgim_pkg::clip_end(in_data.end_y, grid.sy);
    assign az1 = bgim_pkg::clip_end(in_data.end_z, grid.sz);
    assign box_empty = (CW'(in_data.start_x) >= ax1) || (CW'(in_data.start_y) >= ay1) ||
                       (CW'(in_data.start_z) >= az1);

    // Step the neighbour offset in dz, dy, dx order, skip the centre
    always_comb
    begin
        dx_adv = dx_reg;
        dy_adv = dy_reg;
        dz_adv = dz_reg;
        if (dx_reg == bgim_pkg::D_PLUS)
        begin
            dx_adv = bgim_pkg::D_MINUS;
            if (dy_reg == bgim_pkg::D_PLUS)
            begin
                dy_adv = bgim_pkg::D_MINUS;
                dz_adv = dz_reg + 2'd1;
            end
            else
            begin
                dy_adv = dy_reg + 2'd1;
            end
        end
        else
        begin
            dx_adv = dx_reg + 2'd1;
        end
        if (dx_adv == bgim_pkg::D_ZERO && dy_adv == bgim_pkg::D_ZERO &&
            dz_adv == bgim_pkg::D_ZERO)
        begin
            dx_adv = bgim_pkg::D_PLUS;
        end
    end

    // Next state, memory commands and results
    always_comb
    begin
        state_next     = state_reg;
        req_next       = req_reg;
        keep_next      = keep_reg;
        given_next     = given_reg;
        x0_next        = x0_reg;
        y0_next        = y0_reg;
        x1_next        = x1_reg;
        y1_next        = y1_reg;
        z1_next        = z1_reg;
        x_next         = x_reg;
        y_next         = y_reg;
        z_next         = z_reg;
        cx_next        = cx_reg;
        cy_next        = cy_reg;
        cz_next        = cz_reg;
        yz_next        = yz_reg;
        dx_next        = dx_reg;
        dy_next        = dy_reg;
        dz_next        = dz_reg;
        slot_next      = slot_reg;
        nb_phase_next  = nb_phase_reg;
        cset_next      = cset_reg;
        cnum_next      = cnum_reg;
        next_num_next  = next_num_reg;
        ovf_next       = ovf_reg;
        pend_next      = 1'b0;
        pend_addr_next = pend_addr_reg;
        clr_addr_next  = clr_addr_reg;

        in_ready       = 1'b0;
        res_valid      = 1'b0;
        res_data       = '0;
        ram_cmd        = '0;

        // Finish the read-modify-write of the previous box cell
        if (upd_write)
        begin
            ram_cmd.we    = 1'b1;
            ram_cmd.waddr = pend_addr_reg;
            ram_cmd.wdata = {1'b1, (req_reg == bgim_pkg::REQ_ALLOC) ? next_num_reg
                                                                    : given_reg};
        end
        if (upd_adv)
        begin
            if (next_num_reg == bgim_pkg::ALL_ONES)
                ovf_next = 1'b1;
            else
                next_num_next = next_num_reg + 1'b1;
        end

        unique case (state_reg)
            bgim_pkg::ST_CLEAR:
            begin
                ram_cmd.we    = 1'b1;
                ram_cmd.waddr = clr_addr_reg;
                ram_cmd.wdata = '0;
                clr_addr_next = clr_addr_reg + 1'b1;
                if (clr_addr_reg == LAST_ADDR)
                    state_next = bgim_pkg::ST_IDLE;
            end

            bgim_pkg::ST_IDLE:
            begin
                in_ready = 1'b1;
                if (accept)
                begin
                    req_next      = in_data.req_type;
                    keep_next     = in_data.keep_counting;
                    given_next    = in_data.given_number;
                    x0_next       = CW'(in_data.start_x);
                    y0_next       = CW'(in_data.start_y);
                    x_next        = CW'(in_data.start_x);
                    y_next        = CW'(in_data.start_y);
                    z_next        = CW'(in_data.start_z);
                    x1_next       = ax1;
                    y1_next       = ay1;
                    z1_next       = az1;
                    ovf_next      = 1'b0;
                    nb_phase_next = 1'b0;
                    if (in_data.req_type == bgim_pkg::REQ_ALLOC ||
                        in_data.req_type == bgim_pkg::REQ_ASSIGN)
                        state_next = box_empty ? bgim_pkg::ST_RESULT : bgim_pkg::ST_YZ;
                    else
                        state_next = bgim_pkg::ST_MOD;
                end
            end

            bgim_pkg::ST_MOD:
            begin
                // Reduce the cell coordinate one subtraction per cycle
                if (x_reg >= CW'(grid.sx) || y_reg >= CW'(grid.sy) || z_reg >= CW'(grid.sz))
                begin
                    if (x_reg >= CW'(grid.sx))
                        x_next = x_reg - CW'(grid.sx);
                    if (y_reg >= CW'(grid.sy))
                        y_next = y_reg - CW'(grid.sy);
                    if (z_reg >= CW'(grid.sz))
                        z_next = z_reg - CW'(grid.sz);
                end
                else
                begin
                    cx_next    = x_reg;
                    cy_next    = y_reg;
                    cz_next    = z_reg;
                    state_next = bgim_pkg::ST_YZ;
                end
            end

            bgim_pkg::ST_YZ:
            begin
                yz_next = yz_calc;
                if (req_reg == bgim_pkg::REQ_ALLOC || req_reg == bgim_pkg::REQ_ASSIGN)
                    state_next = bgim_pkg::ST_BOX;
                else
                    state_next = bgim_pkg::ST_RD;
            end

            bgim_pkg::ST_BOX:
            begin
                // Issue one cell read per cycle along the row
                ram_cmd.re     = 1'b1;
                ram_cmd.raddr  = rd_addr;
                pend_next      = 1'b1;
                pend_addr_next = rd_addr;
                if (x_reg + 1'b1 < x1_reg)
                begin
                    x_next = x_reg + 1'b1;
                end
                else
                begin
                    x_next = x0_reg;
                    if (y_reg + 1'b1 < y1_reg)
                    begin
                        y_next     = y_reg + 1'b1;
                        state_next = bgim_pkg::ST_YZ;
                    end
                    else
                    begin
                        y_next = y0_reg;
                        if (z_reg + 1'b1 < z1_reg)
                        begin
                            z_next     = z_reg + 1'b1;
                            state_next = bgim_pkg::ST_YZ;
                        end
                        else
                        begin
                            state_next = bgim_pkg::ST_RESULT;
                        end
                    end
                end
            end

            bgim_pkg::ST_RESULT:
            begin
                // Wait for the last cell update before reporting the counter
                res_valid              = !pend_reg;
                res_data.counter_value = next_num_reg;
                res_data.overflow      = ovf_reg;
                res_data.last          = 1'b1;
                if (res_valid && res_ready)
                    state_next = bgim_pkg::ST_IDLE;
            end

            bgim_pkg::ST_RD:
            begin
                ram_cmd.re    = 1'b1;
                ram_cmd.raddr = rd_addr;
                state_next    = bgim_pkg::ST_WAIT;
            end

            bgim_pkg::ST_WAIT:
            begin
                if (req_reg != bgim_pkg::REQ_NEIGH)
                begin
                    res_valid              = 1'b1;
                    res_data.brick_number  = cell_val;
                    res_data.counter_value = next_num_reg;
                    res_data.unassigned    = !cell_set;
                    res_data.last          = 1'b1;
                    if (res_ready)
                        state_next = bgim_pkg::ST_IDLE;
                end
                else if (!nb_phase_reg)
                begin
                    // Hold the centre cell, start at the first neighbour
                    cset_next     = cell_set;
                    cnum_next     = cell_val;
                    nb_phase_next = 1'b1;
                    dx_next       = bgim_pkg::D_MINUS;
                    dy_next       = bgim_pkg::D_MINUS;
                    dz_next       = bgim_pkg::D_MINUS;
                    slot_next     = '0;
                    state_next    = bgim_pkg::ST_NB_PREP;
                end
                else
                begin
                    res_valid              = 1'b1;
                    res_data.brick_number  = cell_val;
                    res_data.owner_number  = cnum_reg;
                    res_data.slot          = slot_reg;
                    res_data.counter_value = next_num_reg;
                    res_data.unassigned    = !(cell_set && cset_reg);
                    res_data.last          = (slot_reg == LAST_SLOT);
                    if (res_ready)
                    begin
                        if (slot_reg == LAST_SLOT)
                        begin
                            state_next = bgim_pkg::ST_IDLE;
                        end
                        else
                        begin
                            dx_next    = dx_adv;
                            dy_next    = dy_adv;
                            dz_next    = dz_adv;
                            slot_next  = slot_reg + 1'b1;
                            state_next = bgim_pkg::ST_NB_PREP;
                        end
                    end
                end
            end

            bgim_pkg::ST_NB_PREP:
            begin
                x_next     = bgim_pkg::wrap_coord(cx_reg, dx_reg, grid.sx);
                y_next     = bgim_pkg::wrap_coord(cy_reg, dy_reg, grid.sy);
                z_next     = bgim_pkg::wrap_coord(cz_reg, dz_reg, grid.sz);
                state_next = bgim_pkg::ST_YZ;
            end

            default:
            begin
                state_next = bgim_pkg::ST_IDLE;
            end
        endcase
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= bgim_pkg::ST_CLEAR;
            clr_addr_reg <= '0;
            pend_reg     <= 1'b0;
            nb_phase_reg <= 1'b0;
            next_num_reg <= '0;
            ovf_reg      <= 1'b0;
            req_reg      <= bgim_pkg::REQ_ALLOC;
        end
        else
        begin
            state_reg    <= state_next;
            clr_addr_reg <= clr_addr_next;
            pend_reg     <= pend_next;
            nb_phase_reg <= nb_phase_next;
            next_num_reg <= next_num_next;
            ovf_reg      <= ovf_next;
            req_reg      <= req_next;
        end
    end

    // Request payload and walk coordinates
    always_ff @(posedge clk)
    begin
        keep_reg      <= keep_next;
        given_reg     <= given_next;
        x0_reg        <= x0_next;
        y0_reg        <= y0_next;
        x1_reg        <= x1_next;
        y1_reg        <= y1_next;
        z1_reg        <= z1_next;
        x_reg         <= x_next;
        y_reg         <= y_next;
        z_reg         <= z_next;
        cx_reg        <= cx_next;
        cy_reg        <= cy_next;
        cz_reg        <= cz_next;
        yz_reg        <= yz_next;
        dx_reg        <= dx_next;
        dy_reg        <= dy_next;
        dz_reg        <= dz_next;
        slot_reg      <= slot_next;
        cset_reg      <= cset_next;
        cnum_reg      <= cnum_next;
        pend_addr_reg <= pend_addr_next;
    end

endmodule

FILE: rtl/brick_grid_index_map_core.sv
// Channel   Direction  Payload                       Handshake
// cfg       in         cfg_index, cfg_wdata          cfg_we, no wait
// in        in         in_data  (bgim_pkg::in_item_t)   in_valid / in_ready
// out       out        out_data (bgim_pkg::out_item_t)  out_valid / out_ready
//
// After reset a clearing pass writes every cell unassigned, one cell per cycle,
// with in_ready low.
// Allocate / assign: one memory read per cell, the write-back overlapping the next
// read, plus a row-index step (ST_YZ) per box row and the ST_RESULT report.
// Lookup: coordinate reduction by repeated subtraction, then ST_YZ, ST_RD, ST_WAIT.
// Neighbours: centre read, then NB_PREP, YZ, RD, WAIT per neighbour (26 results).
// One output register decouples the result side; a stalled out_ready holds the
// sequencer only when that register is full.
module brick_grid_index_map_core (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_we,
    input  logic [bgim_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [bgim_pkg::CFG_DATA_W-1:0]   cfg_wdata,
    input  logic                              in_valid,
    output logic                              in_ready,
    input  bgim_pkg::in_item_t                in_data,
    output logic                              out_valid,
    input  logic                              out_ready,
    output bgim_pkg::out_item_t               out_data
);

    logic [bgim_pkg::SIZE_W-1:0] size_x_reg, size_y_reg, size_z_reg;
    bgim_pkg::grid_size_t        grid;
    bgim_pkg::ram_cmd_t          ram_cmd;
    logic [bgim_pkg::CELL_W-1:0] ram_rdata;
    logic                        res_valid;
    logic                        res_ready;
    bgim_pkg::out_item_t         res_data;
    logic                        out_valid_reg;
    bgim_pkg::out_item_t         out_data_reg;

    // Size registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            size_x_reg <= bgim_pkg::SIZE_RESET;
            size_y_reg <= bgim_pkg::SIZE_RESET;
            size_z_reg <= bgim_pkg::SIZE_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                bgim_pkg::CFG_SIZE_X: size_x_reg <= cfg_wdata;
                bgim_pkg::CFG_SIZE_Y: size_y_reg <= cfg_wdata;
                bgim_pkg::CFG_SIZE_Z: size_z_reg <= cfg_wdata;
                default:              size_x_reg <= size_x_reg;
            endcase
        end
    end

    // Effective extents
    assign grid.sx = bgim_pkg::eff_size(size_x_reg, bgim_pkg::MAX_X);
    assign grid.sy = bgim_pkg::eff_size(size_y_reg, bgim_pkg::MAX_Y);
    assign grid.sz = bgim_pkg::eff_size(size_z_reg, bgim_pkg::MAX_Z);

    bgim_seq u_seq (
        .clk       (clk),
        .rst_n     (rst_n),
        .grid      (grid),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res_data  (res_data),
        .ram_cmd   (ram_cmd),
        .ram_rdata (ram_rdata)
    );

    bgim_ram #(
        .WIDTH (bgim_pkg::CELL_W),
        .DEPTH (bgim_pkg::CELL_COUNT)
    ) u_cell_ram (
        .clk   (clk),
        .we    (ram_cmd.we),
        .waddr (ram_cmd.waddr),
        .wdata (ram_cmd.wdata),
        .re    (ram_cmd.re),
        .raddr (ram_cmd.raddr),
        .rdata (ram_rdata)
    );

    // Output register: load when empty or being drained
    assign res_ready = !out_valid_reg || out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (res_valid && res_ready)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_valid && res_ready)
        begin
            out_data_reg <= res_data;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule

FILE: rtl/bgim_checker.sv
module bgim_checker (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    input  logic                in_ready,
    input  logic                out_valid,
    input  logic                out_ready,
    input  bgim_pkg::out_item_t out_data
);

    // Stalled result transaction holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_data))
        else $error("result changed or dropped while stalled");

    // One request at a time: ready drops after an accepted transaction
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("request accepted while another is in flight");

    // Overflow only on a box result
    a_ovf_box: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.overflow |-> out_data.last && out_data.slot == '0)
        else $error("overflow on a non-box result");

    // A neighbour burst ends on the final slot
    a_last_slot: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.last && out_data.slot != '0 |->
            out_data.slot == bgim_pkg::SLOT_W'(bgim_pkg::NEIGHBOURS - 1))
        else $error("last marks a neighbour slot other than the final one");

endmodule

bind brick_grid_index_map_core bgim_checker u_bgim_checker (.*);
